// ===== hdl/twq_pkg.sv =====
// shared types, constants and width helpers for the timed wait queue
// no dependencies; imported by twq_ctrl, twq_out and timed_wait_queue
`default_nettype none

package twq_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int TICK_W  = 16;
    localparam int FIELD_W = 16;
    localparam int OCC_W   = 5;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SLOT_W  = ID_BITS + TICK_W;

    // command codes
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // result kinds
    localparam logic [2:0] K_ACK      = 3'd0;
    localparam logic [2:0] K_POPPED   = 3'd1;
    localparam logic [2:0] K_TIMEOUT  = 3'd2;
    localparam logic [2:0] K_FOUND    = 3'd3;
    localparam logic [2:0] K_NOTFOUND = 3'd4;
    localparam logic [2:0] K_FULL     = 3'd5;
    localparam logic [2:0] K_EMPTY    = 3'd6;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [TICK_W-1:0]  ticks;
    } slot_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [FIELD_W-1:0] out_id;
        logic               signalled;
        logic [OCC_W-1:0]   occupancy;
        logic               last;
    } res_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_t            wr_data;
    } ram_req_t;

    // port id to stored id: keep the low ID_BITS bits
    function automatic logic [ID_BITS-1:0] to_slot_id(input logic [FIELD_W-1:0] v);
        logic [31:0] wide;
        wide = {16'b0, v};
        return wide[ID_BITS-1:0];
    endfunction

    // stored id back to the 16-bit port
    function automatic logic [FIELD_W-1:0] from_slot_id(input logic [ID_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[FIELD_W-1:0];
    endfunction

    // entry count to the 5-bit occupancy field
    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] v);
        logic [7:0] wide;
        wide = 8'(v);
        return wide[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/twq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module twq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/twq_out.sv =====
// result register between the controller and the result channel
// depends on twq_pkg
`default_nettype none

module twq_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire twq_pkg::res_t  push_res,
    output logic                can_push,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output twq_pkg::res_t       rsp_res
);
    import twq_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign can_push  = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
            res_reg   <= push_res;
        end
        else if (!rsp_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/twq_ctrl.sv =====
// command sequencer: commands finished in the accept cycle and the slot walk with compaction
// depends on twq_pkg; drives twq_ram through a ram_req_t and feeds twq_out
`default_nettype none

module twq_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [2:0]                   cmd,
    input  wire logic [twq_pkg::FIELD_W-1:0]  task_id,
    input  wire logic [twq_pkg::TICK_W-1:0]   wait_ticks,
    output twq_pkg::ram_req_t                 ram_req,
    input  wire twq_pkg::slot_t               rd_data,
    output logic                              emit,
    output twq_pkg::res_t                     emit_res,
    input  wire logic                         can_push
);
    import twq_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} state_t;
    typedef enum logic [1:0] {M_TICK, M_REMOVE, M_POP, M_FIND} mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic               found_reg, found_next;
    logic [ID_BITS-1:0] found_id_reg, found_id_next;
    logic               pend_valid_reg, pend_valid_next;
    res_t               pend_reg, pend_next;

    logic               accept;
    logic               hold;
    logic               match;
    logic [ID_BITS-1:0] in_id;

    assign req_stall = (state_reg != ST_IDLE) || !can_push;
    assign accept    = req_valid && !req_stall;
    assign in_id     = to_slot_id(task_id);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        proc_valid_next = proc_valid_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        found_id_next   = found_id_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ram_req         = '0;
        emit            = 1'b0;
        emit_res        = '0;
        emit_res.last   = 1'b1;
        hold            = 1'b0;
        match           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // walk setup, used by the commands that go through the slots
                    n_next          = count_reg;
                    rd_idx_next     = '0;
                    wr_idx_next     = '0;
                    proc_valid_next = 1'b0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    key_next        = in_id;
                    unique case (cmd)
                        CMD_PUSH:
                        begin
                            emit = 1'b1;
                            emit_res.out_id = from_slot_id(in_id);
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                emit_res.kind      = K_FULL;
                                emit_res.occupancy = to_occ(count_reg);
                            end
                            else
                            begin
                                ram_req.wr_en         = 1'b1;
                                ram_req.wr_addr       = count_reg[IDX_W-1:0];
                                ram_req.wr_data.id    = in_id;
                                ram_req.wr_data.ticks = wait_ticks;
                                count_next            = count_reg + 1'b1;
                                emit_res.kind         = K_ACK;
                                emit_res.occupancy    = to_occ(count_reg + 1'b1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit          = 1'b1;
                                emit_res.kind = K_EMPTY;
                            end
                            else
                            begin
                                mode_next  = M_POP;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            mode_next  = M_REMOVE;
                            state_next = ST_WALK;
                        end
                        CMD_TICK:
                        begin
                            mode_next  = M_TICK;
                            state_next = ST_WALK;
                        end
                        CMD_FIND:
                        begin
                            mode_next  = M_FIND;
                            state_next = ST_WALK;
                        end
                        CMD_CLEAR:
                        begin
                            count_next    = '0;
                            emit          = 1'b1;
                            emit_res.kind = K_ACK;
                        end
                        default:
                        begin
                            emit               = 1'b1;
                            emit_res.kind      = K_ACK;
                            emit_res.occupancy = to_occ(count_reg);
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // process the slot returned by the last read
                if (proc_valid_reg)
                begin
                    unique case (mode_reg)
                        M_TICK:
                        begin
                            if (rd_data.ticks == TICK_W'(1))
                            begin
                                // expiry: the held timeout goes out first
                                if (pend_valid_reg && !can_push)
                                begin
                                    hold = 1'b1;
                                end
                                else
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        emit          = 1'b1;
                                        emit_res      = pend_reg;
                                        emit_res.last = 1'b0;
                                    end
                                    pend_valid_next     = 1'b1;
                                    pend_next.kind      = K_TIMEOUT;
                                    pend_next.out_id    = from_slot_id(rd_data.id);
                                    pend_next.signalled = 1'b0;
                                    pend_next.occupancy = to_occ(count_reg - 1'b1);
                                    pend_next.last      = 1'b1;
                                    count_next          = count_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                ram_req.wr_en         = 1'b1;
                                ram_req.wr_addr       = wr_idx_reg[IDX_W-1:0];
                                ram_req.wr_data.id    = rd_data.id;
                                ram_req.wr_data.ticks = (rd_data.ticks != '0) ?
                                                        rd_data.ticks - 1'b1 : '0;
                                wr_idx_next           = wr_idx_reg + 1'b1;
                            end
                        end
                        M_REMOVE, M_POP:
                        begin
                            match = (mode_reg == M_POP) ? 1'b1 : (rd_data.id == key_reg);
                            if (!found_reg && match)
                            begin
                                found_next    = 1'b1;
                                found_id_next = rd_data.id;
                            end
                            else
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = wr_idx_reg[IDX_W-1:0];
                                ram_req.wr_data = rd_data;
                                wr_idx_next     = wr_idx_reg + 1'b1;
                            end
                        end
                        M_FIND:
                        begin
                            if (rd_data.id == key_reg)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // issue the next read unless the stage is held
                if (!hold)
                begin
                    if (rd_idx_reg < n_reg)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next     = rd_idx_reg + 1'b1;
                        proc_valid_next = 1'b1;
                    end
                    else
                    begin
                        proc_valid_next = 1'b0;
                    end
                end

                // walk done: deliver the closing result
                if (!proc_valid_reg && (rd_idx_reg == n_reg) && can_push)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    unique case (mode_reg)
                        M_TICK:
                        begin
                            if (pend_valid_reg)
                            begin
                                emit_res = pend_reg;
                            end
                            else
                            begin
                                emit_res.kind      = K_ACK;
                                emit_res.occupancy = to_occ(count_reg);
                            end
                        end
                        M_REMOVE:
                        begin
                            emit_res.out_id = from_slot_id(key_reg);
                            if (found_reg)
                            begin
                                emit_res.kind      = K_ACK;
                                emit_res.occupancy = to_occ(count_reg - 1'b1);
                                count_next         = count_reg - 1'b1;
                            end
                            else
                            begin
                                emit_res.kind      = K_NOTFOUND;
                                emit_res.occupancy = to_occ(count_reg);
                            end
                        end
                        M_POP:
                        begin
                            emit_res.kind      = K_POPPED;
                            emit_res.out_id    = from_slot_id(found_id_reg);
                            emit_res.signalled = 1'b1;
                            emit_res.occupancy = to_occ(count_reg - 1'b1);
                            count_next         = count_reg - 1'b1;
                        end
                        M_FIND:
                        begin
                            emit_res.kind      = found_reg ? K_FOUND : K_NOTFOUND;
                            emit_res.out_id    = from_slot_id(key_reg);
                            emit_res.occupancy = to_occ(count_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= M_TICK;
            count_reg      <= '0;
            n_reg          <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
            key_reg        <= '0;
            found_reg      <= 1'b0;
            found_id_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            proc_valid_reg <= proc_valid_next;
            key_reg        <= key_next;
            found_reg      <= found_next;
            found_id_reg   <= found_id_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/timed_wait_queue.sv =====
// top level of the timed wait queue: controller, slot ram and result register
// depends on twq_pkg, twq_ram, twq_out and twq_ctrl
`default_nettype none

// Timed wait queue: an ordered queue of up to DEPTH waiting task ids, each
// with a tick count (0 waits forever). Ids and counts live in one slot ram
// kept in queue order from slot 0; a request is taken only while the queue
// is idle and the result register can take a result. Push, clear, an empty
// pop and the unused codes finish in the accept cycle. Pop, remove, find and
// tick walk the occupied slots through the ram's single registered read
// port, one slot per cycle unless a tick is held by a stalled result
// channel; pop, remove and tick compact in place through the write port
// behind the read pointer; a stalled result channel delays the end of a walk.
// A tick holds each timeout back until the next one or the end of the walk
// is seen so that the final result carries last. No clearing pass follows
// reset: only slots below the entry count are ever read.

module timed_wait_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request channel
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [2:0]                  cmd,
    input  wire logic [twq_pkg::FIELD_W-1:0] task_id,
    input  wire logic [twq_pkg::TICK_W-1:0]  wait_ticks,
    // result channel
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic [2:0]                       kind,
    output logic [twq_pkg::FIELD_W-1:0]      out_id,
    output logic                             signalled,
    output logic [twq_pkg::OCC_W-1:0]        occupancy,
    output logic                             last
);
    import twq_pkg::*;

    ram_req_t ram_req;
    slot_t    rd_data;
    logic     emit;
    res_t     emit_res;
    logic     can_push;
    res_t     rsp_res;

    // sequencer for all commands
    twq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .task_id    (task_id),
        .wait_ticks (wait_ticks),
        .ram_req    (ram_req),
        .rd_data    (rd_data),
        .emit       (emit),
        .emit_res   (emit_res),
        .can_push   (can_push)
    );

    // slot storage: id and remaining ticks per entry
    twq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data)
    );

    // result register decouples the walk from the result channel
    twq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_res  (emit_res),
        .can_push  (can_push),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_res   (rsp_res)
    );

    assign kind      = rsp_res.kind;
    assign out_id    = rsp_res.out_id;
    assign signalled = rsp_res.signalled;
    assign occupancy = rsp_res.occupancy;
    assign last      = rsp_res.last;

endmodule

`default_nettype wire

// ===== tb/sv/twq_checker.sv =====
`timescale 1ns / 100ps
// result checker for the timed wait queue: watches both channels, keeps a
// shadow copy of the queue and compares every result; depends on twq_pkg

module twq_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  logic [2:0]                  cmd,
    input  logic [twq_pkg::FIELD_W-1:0] task_id,
    input  logic [twq_pkg::TICK_W-1:0]  wait_ticks,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  logic [2:0]                  kind,
    input  logic [twq_pkg::FIELD_W-1:0] out_id,
    input  logic                        signalled,
    input  logic [twq_pkg::OCC_W-1:0]   occupancy,
    input  logic                        last,
    output int                          errors,
    output int                          pending
);
    import twq_pkg::*;

    logic [ID_BITS-1:0] shadow_id    [DEPTH];
    logic [TICK_W-1:0]  shadow_ticks [DEPTH];
    int                 shadow_count;
    res_t               awaited_results [$];

    function automatic void note_result(input logic [2:0] k, input logic [ID_BITS-1:0] id,
                                        input logic sig);
        res_t r;
        r.kind      = k;
        r.out_id    = FIELD_W'(id);
        r.signalled = sig;
        r.occupancy = OCC_W'(shadow_count);
        r.last      = 1'b0;
        awaited_results.push_back(r);
    endfunction

    // close the gap at pos, keeping queue order
    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_id[i]    = shadow_id[i + 1];
            shadow_ticks[i] = shadow_ticks[i + 1];
        end
        if (shadow_count > 0)
            shadow_count--;
    endfunction

    function automatic int locate_id(input logic [ID_BITS-1:0] id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_id[i] == id)
                return i;
        return -1;
    endfunction

    // predict the results of one request and update the shadow queue
    function automatic void apply_queue_cmd(input logic [2:0] c, input logic [FIELD_W-1:0] raw_id,
                                            input logic [TICK_W-1:0] t);
        int                 base_size;
        int                 pos;
        int                 i;
        logic [ID_BITS-1:0] id;
        logic [ID_BITS-1:0] gone;
        res_t               tail;
        id        = raw_id[ID_BITS-1:0];
        base_size = awaited_results.size();
        case (c)
            CMD_PUSH:
                if (shadow_count >= DEPTH)
                    note_result(K_FULL, id, 1'b0);
                else
                begin
                    shadow_id[shadow_count]    = id;
                    shadow_ticks[shadow_count] = t;
                    shadow_count++;
                    note_result(K_ACK, id, 1'b0);
                end
            CMD_POP:
                if (shadow_count == 0)
                    note_result(K_EMPTY, '0, 1'b0);
                else
                begin
                    gone = shadow_id[0];
                    drop_slot(0);
                    note_result(K_POPPED, gone, 1'b1);
                end
            CMD_REMOVE:
            begin
                pos = locate_id(id);
                if (pos >= 0)
                begin
                    drop_slot(pos);
                    note_result(K_ACK, id, 1'b0);
                end
                else
                    note_result(K_NOTFOUND, id, 1'b0);
            end
            CMD_TICK:
            begin
                i = 0;
                while (i < shadow_count)
                begin
                    if (shadow_ticks[i] == TICK_W'(1))
                    begin
                        // expires now, next entry slides into slot i
                        gone = shadow_id[i];
                        drop_slot(i);
                        note_result(K_TIMEOUT, gone, 1'b0);
                    end
                    else
                    begin
                        if (shadow_ticks[i] != '0)
                            shadow_ticks[i] = shadow_ticks[i] - 1'b1;
                        i++;
                    end
                end
                if (awaited_results.size() == base_size)
                    note_result(K_ACK, '0, 1'b0);
            end
            CMD_FIND:
                note_result(locate_id(id) >= 0 ? K_FOUND : K_NOTFOUND, id, 1'b0);
            CMD_CLEAR:
            begin
                shadow_count = 0;
                note_result(K_ACK, '0, 1'b0);
            end
            default:
                note_result(K_ACK, '0, 1'b0);
        endcase
        tail      = awaited_results.pop_back();
        tail.last = 1'b1;
        awaited_results.push_back(tail);
    endfunction

    function automatic void check_field(input string what, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_results.delete();
            errors = 0;
        end
        else
        begin
            if (req_valid === 1'b1 && req_stall === 1'b0)
                apply_queue_cmd(cmd, task_id, wait_ticks);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t result: expected none, actual kind %0h id %0h", $time,
                             kind, out_id);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", FIELD_W'(want.kind), FIELD_W'(kind));
                    check_field("out_id", want.out_id, out_id);
                    check_field("signalled", FIELD_W'(want.signalled), FIELD_W'(signalled));
                    check_field("occupancy", FIELD_W'(want.occupancy), FIELD_W'(occupancy));
                    check_field("last", FIELD_W'(want.last), FIELD_W'(last));
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ===== tb/sv/tb_timed_wait_queue.sv =====
`timescale 1ns / 100ps
// top of the timed wait queue testbench: clock, reset, request stimulus and verdict
// depends on twq_pkg, timed_wait_queue and twq_checker

module tb_timed_wait_queue;

    import twq_pkg::*;

    // codes with no operation behind them, the block should just ack
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // cycles with no request and no result taken before giving up
    localparam int QUIET_LIMIT = 3000;
    // per-phase share of random requests in the run
    localparam int PHASE_ITEMS = 115;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [2:0]         cmd;
    logic [FIELD_W-1:0] task_id;
    logic [TICK_W-1:0]  wait_ticks;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [2:0]         kind;
    logic [FIELD_W-1:0] out_id;
    logic               signalled;
    logic [OCC_W-1:0]   occupancy;
    logic               last;

    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    int sent_count;
    int quiet_cycles;

    timed_wait_queue uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .task_id    (task_id),
        .wait_ticks (wait_ticks),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .kind       (kind),
        .out_id     (out_id),
        .signalled  (signalled),
        .occupancy  (occupancy),
        .last       (last)
    );

    // watches both channels beside the block and counts mismatches
    twq_checker watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .task_id    (task_id),
        .wait_ticks (wait_ticks),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .kind       (kind),
        .out_id     (out_id),
        .signalled  (signalled),
        .occupancy  (occupancy),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: a stuck channel ends the run as a failure
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // present one request and hold it until taken; called and returns at a rising edge
    task automatic issue(input logic [2:0] c, input logic [FIELD_W-1:0] id,
                         input logic [TICK_W-1:0] t);
        // optional gap before the request, valid low meanwhile
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        cmd        <= c;
        task_id    <= id;
        wait_ticks <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // hold off new requests until every predicted result has come back
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // ids mostly from a small pool so finds and removes hit, sometimes anything
    function automatic logic [FIELD_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return FIELD_W'($urandom_range(7));
        else if (r < 85)
            return 16'hFFF8 + FIELD_W'($urandom_range(7));
        return FIELD_W'($urandom_range(16'hFFFF));
    endfunction

    // short timeouts dominate so entries actually expire
    function automatic logic [TICK_W-1:0] pick_ticks();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return '0;
        else if (r < 80)
            return TICK_W'($urandom_range(1, 4));
        else if (r < 95)
            return TICK_W'($urandom_range(5, 40));
        return TICK_W'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [FIELD_W-1:0] noise();
        return FIELD_W'($urandom_range(16'hFFFF));
    endfunction

    initial
    begin
        int          n;
        int          t;
        int          r;
        logic [2:0]  c;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        cmd        = CMD_PUSH;
        task_id    = '0;
        wait_ticks = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        sent_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue corners
        issue(CMD_POP, 16'h0000, 16'h0000);
        issue(CMD_TICK, 16'hFFFF, 16'hFFFF);
        issue(CMD_FIND, 16'h1234, 16'h0000);
        issue(CMD_REMOVE, 16'h1234, 16'h0000);
        // id and timeout extremes, then a duplicate id
        issue(CMD_PUSH, 16'h0000, 16'h0000);
        issue(CMD_PUSH, 16'hFFFF, 16'hFFFF);
        issue(CMD_PUSH, 16'h0005, 16'h0001);
        issue(CMD_PUSH, 16'h0005, 16'h0002);
        issue(CMD_PUSH, 16'h0009, 16'h0001);
        issue(CMD_FIND, 16'h0005, 16'h0000);
        issue(CMD_FIND, 16'hFFFF, 16'h0000);
        // two expiries in one tick, then the later duplicate
        issue(CMD_TICK, 16'h0000, 16'h0000);
        issue(CMD_TICK, 16'h0000, 16'h0000);
        issue(CMD_REMOVE, 16'h0000, 16'h0000);
        issue(CMD_REMOVE, 16'h0000, 16'h0000);
        issue(CMD_POP, 16'h0000, 16'h0000);
        issue(CMD_POP, 16'h0000, 16'h0000);
        // unused codes with busy fields
        issue(CMD_SPARE6, 16'hFFFF, 16'hFFFF);
        issue(CMD_SPARE7, 16'hA5A5, 16'h5A5A);
        // remove takes only the oldest of two equal ids
        issue(CMD_PUSH, 16'h0003, 16'h0000);
        issue(CMD_PUSH, 16'h0003, 16'h0007);
        issue(CMD_REMOVE, 16'h0003, 16'h0000);
        issue(CMD_FIND, 16'h0003, 16'h0000);
        issue(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        issue(CMD_FIND, 16'h0003, 16'h0000);
        drain();

        // random phases: none, sender gaps, receiver stalls, a little of both
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 83;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 83;
                end
                default:
                begin
                    idle_pct  = 11;
                    stall_pct = 11;
                end
            endcase
            while (sent_count < 25 + (p + 1) * PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 18)
                begin
                    // burst of equal timeouts, may overfill, then tick them all out
                    n = $urandom_range(1, DEPTH + 1);
                    t = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++)
                        issue(CMD_PUSH, pick_id(), TICK_W'(t));
                    for (int k = 0; k < t; k++)
                        issue(CMD_TICK, noise(), noise());
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 34)
                        c = CMD_PUSH;
                    else if (r < 58)
                        c = CMD_TICK;
                    else if (r < 70)
                        c = CMD_POP;
                    else if (r < 82)
                        c = CMD_FIND;
                    else if (r < 94)
                        c = CMD_REMOVE;
                    else if (r < 97)
                        c = CMD_CLEAR;
                    else if (r < 98)
                        c = CMD_SPARE6;
                    else
                        c = CMD_SPARE7;
                    if (c == CMD_PUSH || c == CMD_FIND || c == CMD_REMOVE)
                        issue(c, pick_id(), pick_ticks());
                    else
                        issue(c, noise(), noise());
                end
            end
            drain();
        end

        // settle time past the longest walk, then nothing more should show up
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
